FILE: hw/rtl/ptq_pkg.sv
// ----------------------------------------------------------------------------
// ptq_pkg
// Shared constants, types and helpers of the periodic timer queue.
// ----------------------------------------------------------------------------
package ptq_pkg;

  localparam int NUM_SLOTS = 16;
  localparam int SLOT_W    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int TIME_BITS = 48;
  localparam int STAMP_W   = 16;
  localparam int CNT_W     = 5;

  localparam logic [1:0] OP_START = 2'd0;
  localparam logic [1:0] OP_STOP  = 2'd1;
  localparam logic [1:0] OP_TICK  = 2'd2;

  typedef enum logic [1:0] {
    K_START,
    K_STOP,
    K_TICK
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [SLOT_W-1:0]     slot;
    logic [31:0]           delay;
    logic [31:0]           period;
    logic [7:0]            owner;
    logic [7:0]            trigger;
    logic [TIME_BITS-1:0]  now;
  } cmd_t;

  typedef struct packed {
    logic             valid;
    logic             fired;
    logic [7:0]       owner;
    logic [7:0]       trigger;
    logic [CNT_W-1:0] count;
    logic             last;
  } result_t;

  // Saturating add of a time and a 32-bit interval
  function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                   input logic [31:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + (TIME_BITS+1)'(b);
    return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
  endfunction

endpackage

FILE: hw/rtl/ptq_front.sv
// ----------------------------------------------------------------------------
// ptq_front
// Accepts items, drops meaningless ones and queues commands for the engine.
// ----------------------------------------------------------------------------
module ptq_front import ptq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] delay_ms_i,
  input  logic [31:0] period_ms_i,
  input  logic [7:0]  owner_id_i,
  input  logic [7:0]  trigger_bits_i,
  input  logic [47:0] now_ms_i,
  output logic        cmd_valid_o,
  output cmd_t        cmd_o,
  input  logic        cmd_pop_i
);

  cmd_t       fifo_q [2];
  logic       wr_q, rd_q;
  logic [1:0] cnt_q;
  logic       keep, enq;
  cmd_t       cmd_in;

  // Classify the incoming item
  always_comb begin
    keep = 1'b0;
    cmd_in.kind    = K_TICK;
    cmd_in.slot    = SLOT_W'(slot_i);
    cmd_in.delay   = delay_ms_i;
    cmd_in.period  = period_ms_i;
    cmd_in.owner   = owner_id_i;
    cmd_in.trigger = trigger_bits_i;
    cmd_in.now     = TIME_BITS'(now_ms_i);
    case (op_i)
      OP_START: begin
        cmd_in.kind = K_START;
        keep = 32'(slot_i) < 32'(NUM_SLOTS);
      end
      OP_STOP: begin
        cmd_in.kind = K_STOP;
        keep = 32'(slot_i) < 32'(NUM_SLOTS);
      end
      OP_TICK: keep = 1'b1;
      default: keep = 1'b0;
    endcase
  end

  assign in_ready_o  = (cnt_q != 2'd2);
  assign enq         = in_valid_i && in_ready_o && keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign cmd_o       = fifo_q[rd_q];

  // Hold queued commands
  always_ff @(posedge clk_i) begin
    if (enq) fifo_q[wr_q] <= cmd_in;
  end

  // Advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (enq) wr_q <= ~wr_q;
      if (cmd_pop_i) rd_q <= ~rd_q;
      cnt_q <= cnt_q + 2'(enq) - 2'(cmd_pop_i);
    end
  end

endmodule

FILE: hw/rtl/ptq_core.sv
// ----------------------------------------------------------------------------
// ptq_core
// Slot table and sequencer: arms, clears and fires timers in due order.
// ----------------------------------------------------------------------------
module ptq_core import ptq_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    cmd_valid_i,
  input  cmd_t    cmd_i,
  output logic    cmd_pop_o,
  input  logic    emit_ok_i,
  output result_t emit_o
);

  typedef enum logic [2:0] {S_IDLE, S_MARK, S_SCAN, S_FIRE, S_CLOSE} state_e;

  state_e               state_q;
  logic [NUM_SLOTS-1:0] active_q, pending_q;
  logic [TIME_BITS-1:0] due_q   [NUM_SLOTS];
  logic [31:0]          per_q   [NUM_SLOTS];
  logic [7:0]           own_q   [NUM_SLOTS];
  logic [7:0]           trg_q   [NUM_SLOTS];
  logic [STAMP_W-1:0]   arm_q   [NUM_SLOTS];
  logic [STAMP_W-1:0]   stamp_q;
  logic [TIME_BITS-1:0] now_q;
  logic [SLOT_W-1:0]    idx_q, best_idx_q;
  logic                 have_best_q;
  logic [TIME_BITS-1:0] best_due_q;
  logic [STAMP_W-1:0]   best_age_q;
  logic [31:0]          best_per_q;
  logic [7:0]           best_own_q, best_trg_q;
  logic [CNT_W-1:0]     count_q;

  logic                 wr_en, clr_en;
  logic [SLOT_W-1:0]    wr_idx;
  logic [TIME_BITS-1:0] wr_due;
  logic [31:0]          wr_per;
  logic [7:0]           wr_own, wr_trg;
  logic [TIME_BITS-1:0] cand_due;
  logic [STAMP_W-1:0]   cand_age;
  logic                 take, scan_end;

  // Compare the scanned slot against the best so far
  assign cand_due = due_q[idx_q];
  assign cand_age = stamp_q - arm_q[idx_q];
  assign take     = pending_q[idx_q] && (!have_best_q || cand_due < best_due_q ||
                    (cand_due == best_due_q && cand_age > best_age_q));
  assign scan_end = (32'(idx_q) == NUM_SLOTS - 1);

  // Decode the work of this cycle
  always_comb begin
    cmd_pop_o = 1'b0;
    emit_o    = '0;
    wr_en     = 1'b0;
    clr_en    = 1'b0;
    wr_idx    = cmd_i.slot;
    wr_due    = sat_add(cmd_i.now, cmd_i.delay);
    wr_per    = cmd_i.period;
    wr_own    = cmd_i.owner;
    wr_trg    = cmd_i.trigger;
    case (state_q)
      S_IDLE: begin
        if (cmd_valid_i) begin
          case (cmd_i.kind)
            K_STOP: begin
              cmd_pop_o = 1'b1;
              clr_en    = 1'b1;
            end
            K_START: begin
              if (cmd_i.delay != 32'd0) begin
                cmd_pop_o = 1'b1;
                wr_en     = 1'b1;
              end else if (emit_ok_i) begin
                cmd_pop_o      = 1'b1;
                emit_o.valid   = 1'b1;
                emit_o.fired   = 1'b1;
                emit_o.owner   = cmd_i.owner;
                emit_o.trigger = cmd_i.trigger;
                emit_o.last    = 1'b1;
                wr_due         = sat_add(cmd_i.now, cmd_i.period);
                wr_en          = (cmd_i.period != 32'd0);
                clr_en         = (cmd_i.period == 32'd0);
              end
            end
            default: cmd_pop_o = 1'b1;
          endcase
        end
      end
      S_FIRE: begin
        wr_idx = best_idx_q;
        wr_due = sat_add(best_due_q, best_per_q);
        wr_per = best_per_q;
        wr_own = best_own_q;
        wr_trg = best_trg_q;
        if (emit_ok_i) begin
          emit_o.valid   = 1'b1;
          emit_o.fired   = 1'b1;
          emit_o.owner   = best_own_q;
          emit_o.trigger = best_trg_q;
          wr_en          = (best_per_q != 32'd0);
          clr_en         = (best_per_q == 32'd0);
        end
      end
      S_CLOSE: begin
        if (emit_ok_i) begin
          emit_o.valid = 1'b1;
          emit_o.count = count_q;
          emit_o.last  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // Write slot payload
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      due_q[wr_idx] <= wr_due;
      per_q[wr_idx] <= wr_per;
      own_q[wr_idx] <= wr_own;
      trg_q[wr_idx] <= wr_trg;
      arm_q[wr_idx] <= stamp_q;
    end
  end

  // Sequence the commands
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      active_q    <= '0;
      pending_q   <= '0;
      stamp_q     <= '0;
      now_q       <= '0;
      idx_q       <= '0;
      best_idx_q  <= '0;
      have_best_q <= 1'b0;
      best_due_q  <= '0;
      best_age_q  <= '0;
      best_per_q  <= '0;
      best_own_q  <= '0;
      best_trg_q  <= '0;
      count_q     <= '0;
    end else begin
      if (wr_en) begin
        active_q[wr_idx] <= 1'b1;
        stamp_q          <= stamp_q + 1'b1;
      end
      if (clr_en) active_q[wr_idx] <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (cmd_pop_o && cmd_i.kind == K_TICK) begin
            now_q   <= cmd_i.now;
            count_q <= '0;
            state_q <= S_MARK;
          end
        end
        S_MARK: begin
          for (int i = 0; i < NUM_SLOTS; i++) begin
            pending_q[i] <= active_q[i] && (due_q[i] <= now_q);
          end
          idx_q       <= '0;
          have_best_q <= 1'b0;
          state_q     <= S_SCAN;
        end
        S_SCAN: begin
          if (take) begin
            have_best_q <= 1'b1;
            best_idx_q  <= idx_q;
            best_due_q  <= cand_due;
            best_age_q  <= cand_age;
            best_per_q  <= per_q[idx_q];
            best_own_q  <= own_q[idx_q];
            best_trg_q  <= trg_q[idx_q];
          end
          if (scan_end) begin
            idx_q   <= '0;
            state_q <= (have_best_q || take) ? S_FIRE : S_CLOSE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_FIRE: begin
          if (emit_ok_i) begin
            pending_q[best_idx_q] <= 1'b0;
            count_q               <= count_q + 1'b1;
            have_best_q           <= 1'b0;
            idx_q                 <= '0;
            state_q               <= S_SCAN;
          end
        end
        S_CLOSE: begin
          if (emit_ok_i) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: hw/rtl/periodic_timer_queue.sv
// ----------------------------------------------------------------------------
// periodic_timer_queue
// Table of one-shot and periodic timer slots with in-order tick firing.
// ----------------------------------------------------------------------------
// Start and stop items are handled by the engine as they are dequeued; a two-entry
// command queue in front lets items arrive while a tick is being worked off.
// A tick latches the time and marks due slots, then makes one full pass over
// all 16 slots (one slot compare per cycle) and fires the earliest due slot;
// pass and firing repeat until one more pass finds nothing left, and a
// closing result follows. Firing and closing wait while results stall.
// Results leave through a one-entry output register.
module periodic_timer_queue import ptq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  op_i,
  input  logic [3:0]  slot_i,
  input  logic [31:0] delay_ms_i,
  input  logic [31:0] period_ms_i,
  input  logic [7:0]  owner_id_i,
  input  logic [7:0]  trigger_bits_i,
  input  logic [47:0] now_ms_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        fired_o,
  output logic [7:0]  fired_owner_o,
  output logic [7:0]  fired_trigger_o,
  output logic [4:0]  fired_count_o,
  output logic        last_o
);

  logic    cmd_valid, cmd_pop, emit_ok;
  cmd_t    cmd;
  result_t emit;
  result_t out_q;

  ptq_front u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .op_i, .slot_i, .delay_ms_i,
    .period_ms_i, .owner_id_i, .trigger_bits_i, .now_ms_i,
    .cmd_valid_o(cmd_valid), .cmd_o(cmd), .cmd_pop_i(cmd_pop)
  );

  ptq_core u_core (
    .clk_i, .rst_ni, .cmd_valid_i(cmd_valid), .cmd_i(cmd), .cmd_pop_o(cmd_pop),
    .emit_ok_i(emit_ok), .emit_o(emit)
  );

  assign emit_ok = !out_q.valid || out_ready_i;

  // Hold the result until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_q <= '0;
    end else if (emit_ok) begin
      out_q <= emit;
    end
  end

  assign out_valid_o     = out_q.valid;
  assign fired_o         = out_q.fired;
  assign fired_owner_o   = out_q.owner;
  assign fired_trigger_o = out_q.trigger;
  assign fired_count_o   = out_q.count;
  assign last_o          = out_q.last;

endmodule
